// File: hw/rtl/assert_macros.svh
// assertion helpers, compiled out when NO_ASSERTIONS is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked on every rising edge while reset is released
`define ASSERT_SYNC(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_SYNC(label, clk, rst_n, prop, msg)

`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: hw/rtl/stc_pkg.sv
package stc_pkg;

    // timer ticks in one second
    localparam int TICKS_PER_SEC = 18;

    localparam int KEY_W     = 8;
    localparam int TICK_CNT_W = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_KEY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_KEY = 1'b1;

    localparam logic [KEY_W-1:0] RESET_KEY_DEFAULT = 8'd48;
    localparam logic [KEY_W-1:0] PAUSE_KEY_DEFAULT = 8'd43;

    // digit tops
    localparam logic [3:0] ONES_TOP = 4'd9;
    localparam logic [2:0] TENS_TOP = 3'd5;
    localparam logic [3:0] HOURS_TOP = 4'd9;

    typedef struct packed {
        logic [3:0] hours;
        logic [2:0] minutes_tens;
        logic [3:0] minutes_ones;
        logic [2:0] seconds_tens;
        logic [3:0] seconds_ones;
        logic [3:0] tenths;
    } t_digits;

    typedef logic [2**TICK_CNT_W-1:0][3:0] t_tenths_tab;

    // tick count to tenths digit, worked out at elaboration
    function automatic t_tenths_tab build_tenths_tab();
        t_tenths_tab tab;
        for (int i = 0; i < 2**TICK_CNT_W; i++) begin
            tab[i] = 4'((i * 10) / TICKS_PER_SEC);
        end
        return tab;
    endfunction

    localparam t_tenths_tab TENTHS_TAB = build_tenths_tab();

endpackage

// File: hw/rtl/stc_if.sv
// request channel: one tick flag and one key code
interface stc_in_if;
    logic       valid;
    logic       ready;
    logic       tick;
    logic [7:0] key;

    modport source (output valid, output tick, output key, input ready);
    modport sink   (input valid, input tick, input key, output ready);
endinterface

// result channel: the digits and the run flag after each request
interface stc_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] hours;
    logic [2:0] minutes_tens;
    logic [3:0] minutes_ones;
    logic [2:0] seconds_tens;
    logic [3:0] seconds_ones;
    logic [3:0] tenths;
    logic       running;

    modport source (output valid, output hours, output minutes_tens, output minutes_ones,
                    output seconds_tens, output seconds_ones, output tenths,
                    output running, input ready);
    modport sink   (input valid, input hours, input minutes_tens, input minutes_ones,
                    input seconds_tens, input seconds_ones, input tenths,
                    input running, output ready);
endinterface

// File: hw/rtl/stopwatch_tenths_counter.sv
// channel   | direction | payload
// ----------+-----------+----------------------------------------------------
// i_req     | in        | tick (1), key (8)
// o_res     | out       | hours, minutes tens/ones, seconds tens/ones, tenths,
//           |           | running
// i_cfg_*   | in        | write port: reset_key (index 0), pause_key (index 1)
//
// one request per cycle while i_req.ready is high; the state update and digit
// carry finish in the cycle the request is taken; the result reaches o_res via
// the result register plus a one-entry skid stage, which let a request in while a
// result waits; i_req.ready drops only when both are full
// synchronous active-low reset clears the counters, the key codes to their
// defaults and both result stages; i_req.ready is low during reset
`include "assert_macros.svh"

module stopwatch_tenths_counter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    stc_in_if.sink                            i_req,
    stc_out_if.source                         o_res,
    input  logic                              i_cfg_we,
    input  logic [stc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [stc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // key code registers
    logic [stc_pkg::KEY_W-1:0] r_reset_key;
    logic [stc_pkg::KEY_W-1:0] r_pause_key;

    // stopwatch state
    logic                           r_paused, n_paused;
    logic [stc_pkg::TICK_CNT_W-1:0] r_tick_cnt, n_tick_cnt;
    stc_pkg::t_digits               r_dig, n_dig;

    // result register and skid stage
    logic             r_out_v, r_skid_v;
    stc_pkg::t_digits r_out_dig, r_skid_dig;
    logic             r_out_run, r_skid_run;

    logic                         req_acc;
    logic                         res_take;
    logic [stc_pkg::TICK_CNT_W:0] tick_next;

    assign i_req.ready = i_rst_n && !r_skid_v;
    assign req_acc     = i_req.valid && i_req.ready;
    assign res_take    = r_out_v && o_res.ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_key <= stc_pkg::RESET_KEY_DEFAULT;
            r_pause_key <= stc_pkg::PAUSE_KEY_DEFAULT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                stc_pkg::CFG_RESET_KEY: r_reset_key <= i_cfg_data;
                stc_pkg::CFG_PAUSE_KEY: r_pause_key <= i_cfg_data;
            endcase
        end
    end

    // next state: tick first, then the key
    always_comb begin
        n_paused   = r_paused;
        n_tick_cnt = r_tick_cnt;
        n_dig      = r_dig;
        tick_next  = {1'b0, r_tick_cnt} + 1'b1;

        if (!r_paused && i_req.tick) begin
            if (tick_next >= (stc_pkg::TICK_CNT_W + 1)'(stc_pkg::TICKS_PER_SEC)) begin
                // full second: clear tenths and ripple the carry upward
                n_tick_cnt   = '0;
                n_dig.tenths = '0;
                if (r_dig.seconds_ones < stc_pkg::ONES_TOP) begin
                    n_dig.seconds_ones = r_dig.seconds_ones + 1'b1;
                end else begin
                    n_dig.seconds_ones = '0;
                    if (r_dig.seconds_tens < stc_pkg::TENS_TOP) begin
                        n_dig.seconds_tens = r_dig.seconds_tens + 1'b1;
                    end else begin
                        n_dig.seconds_tens = '0;
                        if (r_dig.minutes_ones < stc_pkg::ONES_TOP) begin
                            n_dig.minutes_ones = r_dig.minutes_ones + 1'b1;
                        end else begin
                            n_dig.minutes_ones = '0;
                            if (r_dig.minutes_tens < stc_pkg::TENS_TOP) begin
                                n_dig.minutes_tens = r_dig.minutes_tens + 1'b1;
                            end else begin
                                n_dig.minutes_tens = '0;
                                // hours wrap back to zero after nine
                                if (r_dig.hours < stc_pkg::HOURS_TOP) begin
                                    n_dig.hours = r_dig.hours + 1'b1;
                                end else begin
                                    n_dig.hours = '0;
                                end
                            end
                        end
                    end
                end
            end else begin
                n_tick_cnt   = tick_next[stc_pkg::TICK_CNT_W-1:0];
                n_dig.tenths = stc_pkg::TENTHS_TAB[tick_next[stc_pkg::TICK_CNT_W-1:0]];
            end
        end

        // reset key wins when both codes match
        if (i_req.key == r_reset_key) begin
            n_dig    = '0;
            n_paused = 1'b1;
        end else if (i_req.key == r_pause_key) begin
            n_paused = !r_paused;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paused   <= 1'b0;
            r_tick_cnt <= '0;
            r_dig      <= '0;
        end else if (req_acc) begin
            r_paused   <= n_paused;
            r_tick_cnt <= n_tick_cnt;
            r_dig      <= n_dig;
        end
    end

    // result register with skid stage behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (req_acc) begin
                if (!r_out_v || res_take) begin
                    r_out_v <= 1'b1;
                end else begin
                    r_skid_v <= 1'b1;
                end
            end else if (res_take) begin
                if (r_skid_v) begin
                    r_skid_v <= 1'b0;
                end else begin
                    r_out_v <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            if (!r_out_v || res_take) begin
                r_out_dig <= n_dig;
                r_out_run <= !n_paused;
            end else begin
                r_skid_dig <= n_dig;
                r_skid_run <= !n_paused;
            end
        end else if (res_take && r_skid_v) begin
            r_out_dig <= r_skid_dig;
            r_out_run <= r_skid_run;
        end
    end

    assign o_res.valid        = r_out_v;
    assign o_res.hours        = r_out_dig.hours;
    assign o_res.minutes_tens = r_out_dig.minutes_tens;
    assign o_res.minutes_ones = r_out_dig.minutes_ones;
    assign o_res.seconds_tens = r_out_dig.seconds_tens;
    assign o_res.seconds_ones = r_out_dig.seconds_ones;
    assign o_res.tenths       = r_out_dig.tenths;
    assign o_res.running      = r_out_run;

    // skid only fills behind a held result
    `ASSERT_SYNC(a_skid_behind_out, i_clk, i_rst_n, r_skid_v |-> r_out_v, "skid full with result register empty")
    // tens digits, hours and tick count stay in range
    `ASSERT_SYNC(a_digit_range, i_clk, i_rst_n, (r_dig.seconds_tens <= stc_pkg::TENS_TOP) && (r_dig.minutes_tens <= stc_pkg::TENS_TOP) && (r_dig.hours <= stc_pkg::HOURS_TOP), "digit out of range")
    `ASSERT_SYNC(a_tick_range, i_clk, i_rst_n, r_tick_cnt < stc_pkg::TICK_CNT_W'(stc_pkg::TICKS_PER_SEC), "tick count at or above limit")
    // reset key leaves the watch paused with cleared digits
    `ASSERT_SYNC(a_reset_key, i_clk, i_rst_n, (req_acc && (i_req.key == r_reset_key)) |=> (r_paused && (r_dig == '0)), "reset key did not clear and pause")

endmodule
